/* design/direct_mapped_cache_tag_check_assert.svh */
// Assertion macros for the tag check block and its checker.
`ifndef DIRECT_MAPPED_CACHE_TAG_CHECK_ASSERT_SVH
`define DIRECT_MAPPED_CACHE_TAG_CHECK_ASSERT_SVH

// same-cycle implication, masked during reset
`define DMC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define DMC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers reset itself
`define DMC_ASSERT_RST(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/dmc_pkg.sv */
package dmc_pkg;

  typedef struct packed {
    logic [31:0] address;
    logic        is_write;
  } dmc_req_t;

  typedef struct packed {
    logic [4:0]  byte_offset;
    logic [26:0] block_number;
    logic [6:0]  line_index;
    logic [19:0] tag_value;
    logic        miss;
    logic        mem_read;
    logic [5:0]  mem_read_size;
    logic        mem_write;
    logic        mem_write_size;
    logic        replaced;
    logic [19:0] evicted_tag;
  } dmc_resp_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;   // clear one valid entry, advance sweep counter
    logic load;    // capture request, read tag/valid of its line
    logic lookup;  // compare, update line, register the result
  } dmc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
  } dmc_status_t;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned TAG_W  = 20;

  function automatic int unsigned floor_log2(input int unsigned v);
    int unsigned n;
    n = 0;
    for (int i = 1; i < 32; i++) begin
      if (v >= (32'd1 << i)) n = i;
    end
    return n;
  endfunction

endpackage

/* design/direct_mapped_cache_tag_check.sv */
// Tag check of a direct-mapped, write-through, no-write-allocate cache.
// An access is taken when start is high and busy is low; its result shows
// on resp for exactly one cycle with done high, two cycles after the
// access is taken, and must be captured then since it cannot be held off.
// A new access may be started in the cycle that done is high, so accesses
// run at one every two cycles: one cycle for the registered read of the
// tag/valid memory, one to compare and update the line. After reset, busy
// stays high for 2**floor(log2(NUM_LINES)) cycles (128 by default) while
// the valid bits are swept clear.
module direct_mapped_cache_tag_check #(
  parameter int unsigned NUM_LINES   = 128,
  parameter int unsigned BLOCK_BYTES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  dmc_pkg::dmc_req_t  req,
  output logic               done,
  output dmc_pkg::dmc_resp_t resp
);
  import dmc_pkg::*;

  dmc_cmd_t    cmd;
  dmc_status_t status;

  dmc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  dmc_datapath #(
    .NUM_LINES   (NUM_LINES),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .req    (req),
    .status (status),
    .resp   (resp)
  );

endmodule

/* design/dmc_ctrl.sv */
module dmc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  dmc_pkg::dmc_status_t status,
  output dmc_pkg::dmc_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);
  import dmc_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign busy   = (state == ST_CLEAR) || (state == ST_LOOKUP);
  assign done   = (state == ST_DONE);
  assign accept = start && !busy;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state) inside
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE, ST_DONE: begin
        cmd.load = accept;
        if (accept) state_next = ST_LOOKUP;
        else        state_next = ST_IDLE;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_DONE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

endmodule

/* design/dmc_datapath.sv */
module dmc_datapath #(
  parameter int unsigned NUM_LINES   = 128,
  parameter int unsigned BLOCK_BYTES = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dmc_pkg::dmc_cmd_t    cmd,
  input  dmc_pkg::dmc_req_t    req,
  output dmc_pkg::dmc_status_t status,
  output dmc_pkg::dmc_resp_t   resp
);
  import dmc_pkg::*;

  localparam int unsigned OB    = floor_log2(BLOCK_BYTES);
  localparam int unsigned IB    = floor_log2(NUM_LINES);
  localparam int unsigned TB    = OB + IB;
  localparam int unsigned LINES = 1 << IB;
  localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'((64'd1 << OB) - 64'd1);
  localparam logic [ADDR_W-1:0] IDX_MASK = ADDR_W'((64'd1 << IB) - 64'd1);
  localparam logic [5:0]        RD_SIZE  = 6'(BLOCK_BYTES % 64);

  logic [TAG_W-1:0] tag_mem   [LINES];
  logic             valid_mem [LINES];

  logic [IB-1:0]     clear_cnt;
  logic [ADDR_W-1:0] addr_q;
  logic              wr_q;
  logic [TAG_W-1:0]  tag_rd;
  logic              valid_rd;

  logic [ADDR_W-1:0] off32, blk32, idx32, tag32;
  logic [IB-1:0]     idx;
  logic [TAG_W-1:0]  tag;
  logic [IB-1:0]     idx_in;
  logic              miss, allocate, replaced;

  assign status.clear_last = (clear_cnt == '1);

  always_ff @(posedge clk) begin
    if (rst) clear_cnt <= '0;
    else if (cmd.clear) clear_cnt <= clear_cnt + 1'b1;
  end

  // line index of the incoming request, for the registered memory read
  assign idx_in = IB'(req.address >> OB);

  assign off32 = addr_q & OFF_MASK;
  assign blk32 = addr_q >> OB;
  assign idx32 = blk32 & IDX_MASK;
  assign tag32 = addr_q >> TB;
  assign idx   = idx32[IB-1:0];
  assign tag   = tag32[TAG_W-1:0];

  assign miss     = !(valid_rd && (tag_rd == tag));
  assign allocate = cmd.lookup && !wr_q && miss;
  assign replaced = !wr_q && miss && valid_rd;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_q   <= req.address;
      wr_q     <= req.is_write;
      tag_rd   <= tag_mem[idx_in];
      valid_rd <= valid_mem[idx_in];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      valid_mem[clear_cnt] <= 1'b0;
    end else if (allocate) begin
      valid_mem[idx] <= 1'b1;
      tag_mem[idx]   <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      resp.byte_offset    <= off32[4:0];
      resp.block_number   <= blk32[26:0];
      resp.line_index     <= idx32[6:0];
      resp.tag_value      <= tag;
      resp.miss           <= miss;
      resp.mem_read       <= !wr_q && miss;
      resp.mem_read_size  <= (!wr_q && miss) ? RD_SIZE : 6'd0;
      resp.mem_write      <= wr_q;
      resp.mem_write_size <= wr_q;
      resp.replaced       <= replaced;
      resp.evicted_tag    <= replaced ? tag_rd : '0;
    end
  end

endmodule

/* design/dmc_checker.sv */
`include "direct_mapped_cache_tag_check_assert.svh"

module dmc_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input dmc_pkg::dmc_resp_t resp
);
  import dmc_pkg::*;

  logic accept;
  logic rd_miss;
  logic rd_and_wr;
  assign accept    = start && !busy;
  assign rd_miss   = resp.miss && resp.mem_read;
  assign rd_and_wr = resp.mem_read && resp.mem_write;

  `DMC_ASSERT_RST(a_clear_after_reset, rst, busy, "not busy after reset")
  `DMC_ASSERT_IMP(a_result_latency, accept, ##2 done, "result missing after transaction")
  `DMC_ASSERT_NXT(a_single_result, done, !done, "result repeated")
  `DMC_ASSERT_IMP(a_replace_is_miss, done && resp.replaced, rd_miss, "replace without read miss")
  `DMC_ASSERT_IMP(a_rd_wr_exclusive, done, !rd_and_wr, "read and write together")

endmodule

bind direct_mapped_cache_tag_check dmc_checker u_dmc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .resp  (resp)
);

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import dmc_pkg::*;

  localparam int unsigned LINES        = 128;
  localparam int unsigned BLOCK_BYTES  = 32;
  localparam int unsigned PHASES       = 5;
  localparam int unsigned PHASE_ITEMS  = 287;
  localparam int unsigned CYCLE_CAP    = 200000;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned HOT_TAGS     = 4;
  localparam int unsigned HOT_LINES    = 6;
  localparam int unsigned DIRECTED_N   = 17;

  // hand-picked accesses: allocate, hit, write-through, write to invalid and
  // to mismatched lines, replacement with extreme tags, alternating bits
  localparam logic [31:0] DIRECTED_ADDR [DIRECTED_N] = '{
    32'h0000_0000, 32'h0000_001F, 32'h0000_0004, 32'hFFFF_FFFF,
    32'hFFFF_FFE0, 32'hFFFF_FFFF, 32'h0000_0FFF, 32'hFFFF_FFF0,
    32'h0000_0FE0, 32'hFFFF_F000, 32'h0000_0000, 32'h8000_0000,
    32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
    32'h0000_0FE0
  };
  localparam bit DIRECTED_WR [DIRECTED_N] = '{
    1'b0, 1'b0, 1'b1, 1'b1,
    1'b0, 1'b0, 1'b1, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b1, 1'b0,
    1'b1
  };
  // per-phase odds in percent, drawn repeatedly, that the sender keeps idling before an access
  localparam int unsigned IDLE_PCT [PHASES] = '{0, 86, 0, 9, 86};

  class cache_outcome_board;
    bit          present[LINES];
    logic [19:0] stored_tag[LINES];
    dmc_resp_t   pending_outcomes[$];
    int unsigned faults;

    function new();
      foreach (present[i]) begin
        present[i]    = 1'b0;
        stored_tag[i] = '0;
      end
      faults = 0;
    endfunction

    function dmc_resp_t predict_access(dmc_req_t a);
      dmc_resp_t   r;
      logic [6:0]  idx;
      logic [19:0] tg;
      bit          hit;
      idx = a.address[11:5];
      tg  = a.address[31:12];
      r   = '0;
      r.byte_offset  = a.address[4:0];
      r.block_number = a.address[31:5];
      r.line_index   = idx;
      r.tag_value    = tg;
      hit    = present[idx] && (stored_tag[idx] == tg);
      r.miss = !hit;
      if (a.is_write) begin
        // write-through, never allocates or touches the line
        r.mem_write      = 1'b1;
        r.mem_write_size = 1'b1;
      end else if (!hit) begin
        r.mem_read      = 1'b1;
        r.mem_read_size = 6'(BLOCK_BYTES);
        if (present[idx]) begin
          r.replaced    = 1'b1;
          r.evicted_tag = stored_tag[idx];
        end
        present[idx]    = 1'b1;
        stored_tag[idx] = tg;
      end
      return r;
    endfunction

    function void take_access(dmc_req_t a);
      pending_outcomes.push_back(predict_access(a));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        faults++;
      end
    endfunction

    function void match_outcome(dmc_resp_t got);
      dmc_resp_t want;
      if (pending_outcomes.size() == 0) begin
        $error("result with no transaction outstanding");
        faults++;
        return;
      end
      want = pending_outcomes.pop_front();
      compare_field("byte_offset",    32'(want.byte_offset),    32'(got.byte_offset));
      compare_field("block_number",   32'(want.block_number),   32'(got.block_number));
      compare_field("line_index",     32'(want.line_index),     32'(got.line_index));
      compare_field("tag_value",      32'(want.tag_value),      32'(got.tag_value));
      compare_field("miss",           32'(want.miss),           32'(got.miss));
      compare_field("mem_read",       32'(want.mem_read),       32'(got.mem_read));
      compare_field("mem_read_size",  32'(want.mem_read_size),  32'(got.mem_read_size));
      compare_field("mem_write",      32'(want.mem_write),      32'(got.mem_write));
      compare_field("mem_write_size", 32'(want.mem_write_size), 32'(got.mem_write_size));
      compare_field("replaced",       32'(want.replaced),       32'(got.replaced));
      compare_field("evicted_tag",    32'(want.evicted_tag),    32'(got.evicted_tag));
    endfunction

    function int unsigned outstanding();
      return pending_outcomes.size();
    endfunction
  endclass

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  dmc_req_t  req   = '0;
  logic      busy;
  logic      done;
  dmc_resp_t resp;

  cache_outcome_board board;
  int unsigned        cycles = 0;
  logic [19:0]        hot_tag[HOT_TAGS];
  logic [6:0]         hot_line[HOT_LINES];

  direct_mapped_cache_tag_check uut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .resp (resp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // results cannot be stalled: grab every strobe
  always @(posedge clk) begin
    if (!rst && done) board.match_outcome(resp);
  end

  function automatic dmc_req_t wild_access();
    dmc_req_t a;
    a.address  = $urandom();
    a.is_write = 1'($urandom_range(1));
    return a;
  endfunction

  // mostly a small working set so hits, conflicts and evictions happen often
  function automatic dmc_req_t working_set_access();
    dmc_req_t a;
    if ($urandom_range(99) < 25) return wild_access();
    a.address  = {hot_tag[$urandom_range(HOT_TAGS - 1)],
                  hot_line[$urandom_range(HOT_LINES - 1)],
                  5'($urandom_range(31))};
    a.is_write = ($urandom_range(99) < 25);
    return a;
  endfunction

  function automatic void reshuffle_working_set();
    foreach (hot_tag[i]) hot_tag[i] = 20'($urandom());
    foreach (hot_line[i]) hot_line[i] = 7'($urandom_range(LINES - 1));
    if ($urandom_range(1)) hot_tag[0] = 20'hFFFFF;
    if ($urandom_range(1)) hot_tag[1] = 20'h00000;
  endfunction

  task automatic issue(input dmc_req_t a);
    start <= 1'b1;
    req   <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.take_access(a);
  endtask

  task automatic hold_off(input int unsigned pct);
    int unsigned n;
    n = 0;
    while ($urandom_range(99) < pct) n++;
    if (n != 0) begin
      start <= 1'b0;
      req   <= wild_access();
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    dmc_req_t a;
    board = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_N; i++) begin
      a.address  = DIRECTED_ADDR[i];
      a.is_write = DIRECTED_WR[i];
      issue(a);
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      reshuffle_working_set();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        hold_off(IDLE_PCT[p]);
        issue(working_set_access());
      end
      // pause until every outstanding result is back
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/dmc_pkg.sv
design/dmc_ctrl.sv
design/dmc_datapath.sv
design/direct_mapped_cache_tag_check.sv
design/dmc_checker.sv
dv/tb.sv
